// File: src/great_circle_distance_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the great-circle distance unit
// Each macro expects clock and reset in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef GREAT_CIRCLE_DISTANCE_UNIT_ASSERT_SVH
`define GREAT_CIRCLE_DISTANCE_UNIT_ASSERT_SVH

// condition holds in the same cycle
`define GCD_ASSERT_SAME(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("gcd assertion failed");

// condition holds in the following cycle
`define GCD_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("gcd assertion failed");

`endif

// File: src/gcd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gcd_pkg
// Widths, constants, types and fixed-point helpers of the distance unit.
// ---------------------------------------------------------------------------
package gcd_pkg;

   localparam int unsigned CORDIC_ITERATIONS_DEF = 24;

   // field widths
   localparam int unsigned LAT_W  = 24;
   localparam int unsigned LON_W  = 25;
   localparam int unsigned RAD_W  = 24;
   localparam int unsigned DIST_W = 26;

   // angle in degree units after the longitude difference
   localparam int unsigned ANG_W = 27;
   // folded angle magnitude, at most a quarter turn
   localparam int unsigned FOLD_W = 23;
   // Q30 datapath width
   localparam int unsigned SC_W = 34;
   // clamped central angle, unsigned
   localparam int unsigned CA_W = 32;

   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
   localparam int unsigned DEG_C_W = 39;
   localparam logic [DEG_C_W-1:0] DEG_TO_RAD_C = DEG_C_W'(PI_Q60 / 64'd11796480);

   localparam logic signed [ANG_W:0] FULL_TURN    = 28'sd23592960;
   localparam logic signed [ANG_W:0] HALF_TURN    = 28'sd11796480;
   localparam logic [ANG_W-1:0]      HALF_MAG     = 27'd11796480;
   localparam logic [ANG_W-1:0]      QUARTER_TURN = 27'd5898240;

   localparam logic signed [SC_W-1:0] GAIN_Q30    = 34'sd652032874;
   localparam logic signed [SC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [SC_W-1:0] PI_Q30      = 34'sd3373259426;

   localparam logic [RAD_W-1:0]  RADIUS_RESET = 24'd6371000;
   localparam logic [DIST_W-1:0] DIST_MAX     = 26'd52707180;

   localparam logic signed [2*SC_W-1:0] MUL_RND = (2*SC_W)'(64'd1 << 29);

   typedef struct packed {
      logic signed [SC_W-1:0] s;
      logic signed [SC_W-1:0] c;
   } sincos_type;

   typedef struct packed {
      logic signed [SC_W-1:0] x;
      logic signed [SC_W-1:0] z;
   } vec_type;

   // atan(2^-i) in Q30, rounded half up
   function automatic logic signed [SC_W-1:0] atan_q30(input int unsigned idx);
      logic signed [SC_W-1:0] t;
      case (idx)
         0: t = 34'sd843314857;
         1: t = 34'sd497837829;
         2: t = 34'sd263043837;
         3: t = 34'sd133525159;
         4: t = 34'sd67021687;
         5: t = 34'sd33543516;
         6: t = 34'sd16775851;
         7: t = 34'sd8388437;
         8: t = 34'sd4194283;
         9: t = 34'sd2097149;
         default: t = (idx >= 30) ? 34'sd1 : (34'sd1 <<< (30 - idx));
      endcase
      return t;
   endfunction

   // Q30 product, rounded half up
   function automatic logic signed [SC_W-1:0] mulq(input logic signed [SC_W-1:0] a,
                                                   input logic signed [SC_W-1:0] b);
      logic signed [2*SC_W-1:0] prod;
      prod = (2*SC_W)'(a) * (2*SC_W)'(b) + MUL_RND;
      return prod[SC_W+29:30];
   endfunction

endpackage

// File: src/gcd_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gcd channels
// Valid/ready channels for requests, responses and the radius register.
// ---------------------------------------------------------------------------
interface gcd_req_if;
   import gcd_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [LAT_W-1:0] lat_a;
   logic signed [LON_W-1:0] lon_a;
   logic signed [LAT_W-1:0] lat_b;
   logic signed [LON_W-1:0] lon_b;
   modport source (output valid, lat_a, lon_a, lat_b, lon_b, input ready);
   modport sink (input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

interface gcd_rsp_if;
   import gcd_pkg::*;
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] distance_m;
   modport source (output valid, distance_m, input ready);
   modport sink (input valid, distance_m, output ready);
endinterface

interface gcd_csr_if;
   import gcd_pkg::*;
   logic             valid;
   logic             ready;
   logic [RAD_W-1:0] sphere_radius_m;
   modport source (output valid, sphere_radius_m, input ready);
   modport sink (input valid, sphere_radius_m, output ready);
endinterface

// File: src/great_circle_distance_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// great_circle_distance_unit
// Great-circle distance of two points in spherical Vincenty form, rounded
// to whole metres, on a fully pipelined CORDIC datapath.
// ---------------------------------------------------------------------------
//   channel | dir | payload                          | moves when
//   req_if  | in  | lat_a, lon_a, lat_b, lon_b       | valid && ready
//   rsp_if  | out | distance_m                       | valid && ready
//   csr_if  | in  | sphere_radius_m                  | valid (ready tied high)
//
// Three rotation pipelines run in parallel, then two vectoring pipelines in
// series, each one stage per iteration, plus reduce, convert, multiply,
// clamp and output stages. A new request is taken every cycle while no
// finished response is stalled. A stalled response freezes the whole
// pipeline, so requests are held in place, never dropped or repeated.
// Reset clears the valid bits and loads the radius with 6371000 m.
// ---------------------------------------------------------------------------
`include "great_circle_distance_unit_assert.svh"

module great_circle_distance_unit #(
   parameter int unsigned CORDIC_ITERATIONS = gcd_pkg::CORDIC_ITERATIONS_DEF
) (
   input logic     clock,
   input logic     reset,
   gcd_req_if.sink req_if,
   gcd_rsp_if.source rsp_if,
   gcd_csr_if.sink csr_if
);
   import gcd_pkg::*;

   localparam int unsigned LAT = 3 * CORDIC_ITERATIONS + 9;

   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] vld_in;
   logic           adv;
   logic [RAD_W-1:0] radius_ff;

   logic signed [ANG_W-1:0] lat_a_ff;
   logic signed [ANG_W-1:0] lat_b_ff;
   logic signed [ANG_W-1:0] dlon_ff;

   sincos_type sc_a;
   sincos_type sc_b;
   sincos_type sc_d;

   logic signed [SC_W-1:0] p1_ff, t1_ff, t2_ff, xs1_ff, t3_ff, cd1_ff;
   logic signed [SC_W-1:0] pabs2_ff, q2_ff, xd2_ff;
   logic signed [SC_W-1:0] xd_dly_ff [CORDIC_ITERATIONS];
   vec_type                v1;
   logic signed [SC_W-1:0] m_in;
   logic signed [SC_W-1:0] m3_ff, xd3_ff;
   logic signed [SC_W-1:0] v2_x, v2_y, v2_z;
   vec_type                v2;
   logic [CA_W-1:0]        ang_in;
   logic [CA_W-1:0]        ang_ff;
   logic [CA_W+RAD_W-1:0]  dist_prod;
   logic [DIST_W-1:0]      dist_ff;

   // advance everything unless a finished response is waiting
   assign adv          = !vld_ff[LAT-1] || rsp_if.ready;
   assign req_if.ready = adv;
   assign vld_in       = {vld_ff[LAT-2:0], req_if.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_if.valid) begin
         radius_ff <= csr_if.sphere_radius_m;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lat_a_ff <= ANG_W'(req_if.lat_a);
         lat_b_ff <= ANG_W'(req_if.lat_b);
         dlon_ff  <= ANG_W'(req_if.lon_b) - ANG_W'(req_if.lon_a);
      end
   end

   gcd_sincos #(.ITER(CORDIC_ITERATIONS)) u_sc_a (
      .clock(clock), .adv(adv), .ang_i(lat_a_ff), .sc_o(sc_a));
   gcd_sincos #(.ITER(CORDIC_ITERATIONS)) u_sc_b (
      .clock(clock), .adv(adv), .ang_i(lat_b_ff), .sc_o(sc_b));
   gcd_sincos #(.ITER(CORDIC_ITERATIONS)) u_sc_d (
      .clock(clock), .adv(adv), .ang_i(dlon_ff), .sc_o(sc_d));

   // first products
   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff  <= mulq(sc_b.c, sc_d.s);
         t1_ff  <= mulq(sc_a.c, sc_b.s);
         t2_ff  <= mulq(sc_a.s, sc_b.c);
         xs1_ff <= mulq(sc_a.s, sc_b.s);
         t3_ff  <= mulq(sc_a.c, sc_b.c);
         cd1_ff <= sc_d.c;
      end
   end

   // cross and dot terms
   always_ff @(posedge clock) begin
      if (adv) begin
         pabs2_ff <= (p1_ff < 0) ? -p1_ff : p1_ff;
         q2_ff    <= t1_ff - mulq(t2_ff, cd1_ff);
         xd2_ff   <= xs1_ff + mulq(t3_ff, cd1_ff);
      end
   end

   gcd_vector #(.ITER(CORDIC_ITERATIONS)) u_root (
      .clock(clock), .adv(adv), .x_i(pabs2_ff), .y_i(q2_ff), .z_i('0), .res_o(v1));

   // carry the dot term alongside the root pipeline
   for (genvar k = 0; k < CORDIC_ITERATIONS; k++) begin : g_xd
      always_ff @(posedge clock) begin
         if (adv) begin
            xd_dly_ff[k] <= (k == 0) ? xd2_ff : xd_dly_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   always_comb begin
      m_in = mulq(v1.x, GAIN_Q30);
      if (m_in < 0) begin
         m_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m3_ff  <= m_in;
         xd3_ff <= xd_dly_ff[CORDIC_ITERATIONS-1];
      end
   end

   // negative dot term: turn by -90 degrees and add pi/2
   always_comb begin
      if (xd3_ff < 0) begin
         v2_x = m3_ff;
         v2_y = -xd3_ff;
         v2_z = HALF_PI_Q30;
      end else begin
         v2_x = xd3_ff;
         v2_y = m3_ff;
         v2_z = '0;
      end
   end

   gcd_vector #(.ITER(CORDIC_ITERATIONS)) u_atan (
      .clock(clock), .adv(adv), .x_i(v2_x), .y_i(v2_y), .z_i(v2_z), .res_o(v2));

   always_comb begin
      if (v2.z < 0) begin
         ang_in = '0;
      end else if (v2.z > PI_Q30) begin
         ang_in = CA_W'(PI_Q30);
      end else begin
         ang_in = CA_W'(v2.z);
      end
   end

   assign dist_prod = (CA_W+RAD_W)'(ang_ff) * (CA_W+RAD_W)'(radius_ff)
                    + (CA_W+RAD_W)'(64'd1 << 29);

   always_ff @(posedge clock) begin
      if (adv) begin
         ang_ff  <= ang_in;
         dist_ff <= dist_prod[DIST_W+29:30];
      end
   end

   assign rsp_if.valid      = vld_ff[LAT-1];
   assign rsp_if.distance_m = dist_ff;

   `GCD_ASSERT_SAME(a_ready_when_drained, !vld_ff[LAT-1], req_if.ready)
   `GCD_ASSERT_SAME(a_distance_bound, rsp_if.valid, rsp_if.distance_m <= DIST_MAX)
   `GCD_ASSERT_NEXT(a_stall_freezes_pipe, !adv, $stable(vld_ff))

endmodule

// File: src/gcd_sincos.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gcd_sincos
// Pipelined sine/cosine of an angle in degree units: reduce, convert to
// radians, rotate through one CORDIC stage per iteration, restore signs.
// ---------------------------------------------------------------------------
module gcd_sincos #(
   parameter int unsigned ITER = gcd_pkg::CORDIC_ITERATIONS_DEF
) (
   input  logic                              clock,
   input  logic                              adv,
   input  logic signed [gcd_pkg::ANG_W-1:0]  ang_i,
   output gcd_pkg::sincos_type               sc_o
);
   import gcd_pkg::*;

   logic signed [ANG_W:0]   ext;
   logic signed [ANG_W:0]   red;
   logic [ANG_W-1:0]        mag;
   logic [FOLD_W-1:0]       fold_in;
   logic                    cneg_in;
   logic [FOLD_W-1:0]       fold_ff;
   logic                    neg_ff;
   logic                    cneg_ff;
   logic [FOLD_W+DEG_C_W-1:0] rad_prod;

   logic signed [SC_W-1:0] x_ff [ITER+1];
   logic signed [SC_W-1:0] y_ff [ITER+1];
   logic signed [SC_W-1:0] z_ff [ITER+1];
   logic                   sneg_ff [ITER+1];
   logic                   cflip_ff [ITER+1];
   sincos_type             sc_ff;

   // reduce to [-180, 180) and fold to [0, 90]
   always_comb begin
      ext = (ANG_W+1)'(ang_i);
      if (ext >= HALF_TURN) begin
         red = ext - FULL_TURN;
      end else if (ext < -HALF_TURN) begin
         red = ext + FULL_TURN;
      end else begin
         red = ext;
      end
      mag = (red < 0) ? ANG_W'(-red) : ANG_W'(red);
      if (mag > QUARTER_TURN) begin
         fold_in = FOLD_W'(HALF_MAG - mag);
         cneg_in = 1'b1;
      end else begin
         fold_in = FOLD_W'(mag);
         cneg_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fold_ff <= fold_in;
         neg_ff  <= red < 0;
         cneg_ff <= cneg_in;
      end
   end

   assign rad_prod = (FOLD_W+DEG_C_W)'(fold_ff) * (FOLD_W+DEG_C_W)'(DEG_TO_RAD_C)
                   + (FOLD_W+DEG_C_W)'(64'd1 << 29);

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0]     <= GAIN_Q30;
         y_ff[0]     <= '0;
         z_ff[0]     <= SC_W'(rad_prod[FOLD_W+DEG_C_W-1:30]);
         sneg_ff[0]  <= neg_ff;
         cflip_ff[0] <= cneg_ff;
      end
   end

   for (genvar i = 0; i < ITER; i++) begin : g_rot
      localparam logic signed [SC_W-1:0] T = atan_q30(i);
      logic signed [SC_W-1:0] dx;
      logic signed [SC_W-1:0] dy;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (adv) begin
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - T;
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + T;
            end
            sneg_ff[i+1]  <= sneg_ff[i];
            cflip_ff[i+1] <= cflip_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sc_ff.s <= sneg_ff[ITER] ? -y_ff[ITER] : y_ff[ITER];
         sc_ff.c <= cflip_ff[ITER] ? -x_ff[ITER] : x_ff[ITER];
      end
   end

   assign sc_o = sc_ff;

endmodule

// File: src/gcd_vector.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gcd_vector
// Pipelined CORDIC in vectoring mode: drives y toward zero, one stage per
// iteration, and returns the final x and the accumulated angle.
// ---------------------------------------------------------------------------
module gcd_vector #(
   parameter int unsigned ITER = gcd_pkg::CORDIC_ITERATIONS_DEF
) (
   input  logic                            clock,
   input  logic                            adv,
   input  logic signed [gcd_pkg::SC_W-1:0] x_i,
   input  logic signed [gcd_pkg::SC_W-1:0] y_i,
   input  logic signed [gcd_pkg::SC_W-1:0] z_i,
   output gcd_pkg::vec_type                res_o
);
   import gcd_pkg::*;

   logic signed [SC_W-1:0] x_ff [ITER];
   logic signed [SC_W-1:0] y_ff [ITER];
   logic signed [SC_W-1:0] z_ff [ITER];

   for (genvar i = 0; i < ITER; i++) begin : g_vec
      localparam logic signed [SC_W-1:0] T = atan_q30(i);
      logic signed [SC_W-1:0] xs;
      logic signed [SC_W-1:0] ys;
      logic signed [SC_W-1:0] zs;
      logic signed [SC_W-1:0] dx;
      logic signed [SC_W-1:0] dy;
      if (i == 0) begin : g_head
         assign xs = x_i;
         assign ys = y_i;
         assign zs = z_i;
      end else begin : g_body
         assign xs = x_ff[i-1];
         assign ys = y_ff[i-1];
         assign zs = z_ff[i-1];
      end
      assign dx = ys >>> i;
      assign dy = xs >>> i;
      always_ff @(posedge clock) begin
         if (adv) begin
            if (ys > 0) begin
               x_ff[i] <= xs + dx;
               y_ff[i] <= ys - dy;
               z_ff[i] <= zs + T;
            end else begin
               x_ff[i] <= xs - dx;
               y_ff[i] <= ys + dy;
               z_ff[i] <= zs - T;
            end
         end
      end
   end

   assign res_o.x = x_ff[ITER-1];
   assign res_o.z = z_ff[ITER-1];

endmodule

// File: verif/gcd_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gcd_checker
// Watches the request, response and radius channels of the distance unit.
// It keeps its own copy of the radius register and predicts each distance
// with a bit-exact CORDIC model. Each response is compared in order.
// ---------------------------------------------------------------------------
module gcd_checker (
   input  logic clock,
   input  logic reset,
   gcd_req_if   req_if,
   gcd_rsp_if   rsp_if,
   gcd_csr_if   csr_if,
   output int   fail_count,
   output int   pending_count
);
   import gcd_pkg::*;

   localparam int unsigned ITERS = CORDIC_ITERATIONS_DEF;
   localparam longint TURN_UNITS    = 64'sd23592960;
   localparam longint HALF_UNITS    = 64'sd11796480;
   localparam longint QUARTER_UNITS = 64'sd5898240;
   localparam longint GAIN          = 64'sd652032874;
   localparam longint HALF_PI       = 64'sd1686629713;
   localparam longint PI_ANGLE      = 64'sd3373259426;
   localparam longint unsigned PI_SHIFTED = 64'h3243F6A8885A308D;
   localparam longint unsigned RAD_PER_UNIT = PI_SHIFTED / 64'd11796480;

   logic [RAD_W-1:0]  radius_m;
   logic [DIST_W-1:0] distance_queue[$];
   longint            arctan_lut[ITERS];

   // atan(2^-i) from its power series, rounded to Q30; index 0 uses pi/4
   function automatic longint arctan_q30(input int unsigned idx);
      longint unsigned term, acc;
      int unsigned     k;
      if (idx == 0) begin
         return longint'((PI_SHIFTED + (64'd1 << 31)) >> 32);
      end
      term = 64'd1 << (62 - idx);
      acc  = term;
      k    = 1;
      while (2 * idx < 63) begin
         term = term >> (2 * idx);
         if (term == 0) break;
         if (k % 2 == 1) acc = acc - term / (2 * k + 1);
         else acc = acc + term / (2 * k + 1);
         k++;
      end
      return longint'((acc + (64'd1 << 31)) >> 32);
   endfunction

   function automatic longint q30_mul(input longint a, input longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   task automatic sin_cos_units(input longint v, output longint s, output longint c);
      longint r, mag, x, y, z, dx, dy;
      bit     neg, flip;
      r = v % TURN_UNITS;
      if (r < 0) r += TURN_UNITS;
      if (r >= HALF_UNITS) r -= TURN_UNITS;
      neg  = r < 0;
      mag  = neg ? -r : r;
      flip = 0;
      if (mag > QUARTER_UNITS) begin
         mag  = HALF_UNITS - mag;
         flip = 1;
      end
      z = longint'((longint'(mag) * RAD_PER_UNIT + (64'd1 << 29)) >> 30);
      x = GAIN;
      y = 0;
      for (int i = 0; i < ITERS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= arctan_lut[i];
         end else begin
            x += dx; y -= dy; z += arctan_lut[i];
         end
      end
      s = neg ? -y : y;
      c = flip ? -x : x;
   endtask

   task automatic vectoring(input longint x0, input longint y0, input longint z0,
                            output longint x_out, output longint z_out);
      longint x, y, z, dx, dy;
      x = x0; y = y0; z = z0;
      for (int i = 0; i < ITERS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; z += arctan_lut[i];
         end else begin
            x -= dx; y += dy; z -= arctan_lut[i];
         end
      end
      x_out = x;
      z_out = z;
   endtask

   task automatic predict_distance(input longint lat_a, input longint lon_a,
                                   input longint lat_b, input longint lon_b,
                                   input logic [RAD_W-1:0] radius,
                                   output logic [DIST_W-1:0] dist_m);
      longint sa, ca, sb, cb, sd, cd, p, q, dot, mag, m, ang, unused;
      longint unsigned scaled;
      sin_cos_units(lat_a, sa, ca);
      sin_cos_units(lat_b, sb, cb);
      sin_cos_units(lon_b - lon_a, sd, cd);
      p   = q30_mul(cb, sd);
      q   = q30_mul(ca, sb) - q30_mul(q30_mul(sa, cb), cd);
      dot = q30_mul(sa, sb) + q30_mul(q30_mul(ca, cb), cd);
      vectoring(p < 0 ? -p : p, q, 0, mag, unused);
      m = q30_mul(mag, GAIN);
      if (m < 0) m = 0;
      // negative dot term: turn by -90 degrees first
      if (dot < 0) vectoring(m, -dot, HALF_PI, unused, ang);
      else vectoring(dot, m, 0, unused, ang);
      if (ang < 0) ang = 0;
      if (ang > PI_ANGLE) ang = PI_ANGLE;
      scaled = (longint'(ang) * longint'(radius) + (64'd1 << 29)) >> 30;
      dist_m = scaled[DIST_W-1:0];
   endtask

   initial begin
      for (int i = 0; i < ITERS; i++) arctan_lut[i] = arctan_q30(i);
   end

   assign pending_count = distance_queue.size();

   always @(posedge clock) begin
      logic [DIST_W-1:0] predicted;
      logic [DIST_W-1:0] expected;
      if (reset) begin
         radius_m   <= RADIUS_RESET;
         fail_count = 0;
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            radius_m <= csr_if.sphere_radius_m;
         end
         if (req_if.valid && req_if.ready) begin
            predict_distance(req_if.lat_a, req_if.lon_a, req_if.lat_b, req_if.lon_b,
                             radius_m, predicted);
            distance_queue = {distance_queue, predicted};
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (distance_queue.size() == 0) begin
               $error("distance_m: no request outstanding, actual %0d",
                      rsp_if.distance_m);
               fail_count++;
            end else begin
               expected = distance_queue.pop_front();
               if (rsp_if.distance_m !== expected) begin
                  $error("distance_m: expected %0d, actual %0d", expected,
                         rsp_if.distance_m);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

// File: verif/great_circle_distance_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// great_circle_distance_unit_tb
// Drives directed and random point pairs through the distance unit under
// several radius settings and idle patterns; the checker predicts and
// compares every distance.
// ---------------------------------------------------------------------------
module great_circle_distance_unit_tb;
   import gcd_pkg::*;

   localparam int DRAIN_CYCLES = 3 * CORDIC_ITERATIONS_DEF + 30;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 186;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic          clock;
   logic          reset;
   int            fail_count;
   int            pending_count;
   int            cycle_count = 0;
   idle_mode_type idle_mode;

   gcd_req_if req_if ();
   gcd_rsp_if rsp_if ();
   gcd_csr_if csr_if ();

   great_circle_distance_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   gcd_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_if        (req_if),
      .rsp_if        (rsp_if),
      .csr_if        (csr_if),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver stalls per idle mode
   always @(negedge clock) begin
      if (idle_mode == IDLE_RECEIVER) rsp_if.ready = ($urandom_range(99) >= 62);
      else if (idle_mode == IDLE_BOTH) rsp_if.ready = ($urandom_range(99) >= 30);
      else rsp_if.ready = 1'b1;
   end

   task automatic send_request(input logic signed [LAT_W-1:0] lat_a,
                               input logic signed [LON_W-1:0] lon_a,
                               input logic signed [LAT_W-1:0] lat_b,
                               input logic signed [LON_W-1:0] lon_b);
      int pct;
      pct = (idle_mode == IDLE_SENDER) ? 62 : (idle_mode == IDLE_BOTH) ? 30 : 0;
      @(negedge clock);
      while ($urandom_range(99) < pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.lat_a = lat_a;
      req_if.lon_a = lon_a;
      req_if.lat_b = lat_b;
      req_if.lon_b = lon_b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // hold off until every distance is back and the pipeline is empty
   task automatic drain_pipeline();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_radius(input logic [RAD_W-1:0] radius);
      drain_pipeline();
      csr_if.valid           = 1'b1;
      csr_if.sphere_radius_m = radius;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   task automatic send_random();
      logic signed [LAT_W-1:0] la, lb;
      logic signed [LON_W-1:0] oa, ob;
      if ($urandom_range(99) < 80) begin
         la = $urandom_range(2 * 5898240) - 5898240;
         lb = $urandom_range(2 * 5898240) - 5898240;
         oa = $urandom_range(2 * 11796480) - 11796480;
         ob = $urandom_range(2 * 11796480) - 11796480;
         // nearby points now and then
         if ($urandom_range(9) == 0) begin
            lb = la + $signed($urandom_range(2000)) - 1000;
            ob = oa + $signed($urandom_range(2000)) - 1000;
         end
      end else begin
         la = $urandom;
         lb = $urandom;
         oa = $urandom;
         ob = $urandom;
      end
      send_request(la, oa, lb, ob);
   endtask

   initial begin
      logic [RAD_W-1:0] radii[5];
      idle_mode_type    modes[5];
      idle_mode     = IDLE_NONE;
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.lat_a  = '0;
      req_if.lon_a  = '0;
      req_if.lat_b  = '0;
      req_if.lon_b  = '0;
      rsp_if.ready  = 1'b1;
      csr_if.valid  = 1'b0;
      csr_if.sphere_radius_m = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes, identical and antipodal points, wrap-around
      send_request(0, 0, 0, 0);
      send_request(5898240, 0, -5898240, 0);
      send_request(0, 0, 0, 11796480);
      send_request(0, -11796480, 0, 11796480);
      send_request(0, 0, 0, -11796480);
      send_request(5898240, 11796480, 5898240, -11796480);
      send_request(-5898240, -11796480, 5898240, 11796480);
      send_request(2949120, 655360, 2949120, 655360);
      send_request(2949120, 655360, -2949120, -11141120);
      send_request(8388607, 16777215, -8388608, -16777216);
      send_request(-8388608, -16777216, 8388607, 16777215);
      send_request(8388607, 0, 0, 0);
      send_request(0, 16777215, 0, -16777216);
      send_request(3000000, 100, 3000001, 101);
      send_request(-1, -1, 1, 1);
      send_request(0, 0, 0, 5898240);
      send_request(0, 0, 0, 5898241);
      send_request(100000, 0, -100000, 11796000);
      send_request(5898239, 1, 5898240, 2);
      send_request(-5898240, 12345, -5898240, 54321);

      radii = '{24'd1, 24'd16777215, 24'd0, 24'($urandom_range(1, 16777215)), RADIUS_RESET};
      modes = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_SENDER};
      for (int ph = 0; ph < 5; ph++) begin
         write_radius(radii[ph]);
         idle_mode = modes[ph];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_random();
            // stretches without idling
            if (n == PHASE_ITEMS / 2) idle_mode = IDLE_NONE;
            if (n == PHASE_ITEMS / 2 + 30) idle_mode = modes[ph];
         end
      end

      drain_pipeline();
      if (fail_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
